FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define EFR_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("efr check failed");

// a implies b in the next cycle
`define EFR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("efr check failed");

`endif

FILE: src/efr_pkg.sv
package efr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CRC_W  = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] SOF_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] EOF_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'hBB;
    localparam logic [BYTE_W-1:0] ESC_SOF  = 8'h0A;
    localparam logic [BYTE_W-1:0] ESC_EOF  = 8'h05;
    localparam logic [BYTE_W-1:0] ESC_ESC  = 8'h0B;

    typedef struct packed {
        logic init;
        logic start;
    } crc_ctrl_t;

    typedef struct packed {
        logic busy;
    } crc_stat_t;

endpackage

FILE: src/efr_ram.sv
module efr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/efr_crc.sv
module efr_crc (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  efr_pkg::crc_ctrl_t       ctrl,
    input  logic [efr_pkg::BYTE_W-1:0] data,
    output efr_pkg::crc_stat_t       stat,
    output logic [efr_pkg::CRC_W-1:0] crc
);
    import efr_pkg::*;

    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    // one bit of the reflected polynomial division per cycle
    always_comb begin
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.init) begin
            crc_next = CRC_INIT;
        end else if (ctrl.start) begin
            crc_next  = crc_reg ^ {{(CRC_W-BYTE_W){1'b0}}, data};
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= CRC_INIT;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign stat.busy = busy_reg;
    assign crc       = crc_reg;

endmodule

FILE: src/escaped_frame_receiver_crc16.sv
// channel   dir  handshake           payload
// s_        in   s_valid / s_ready   s_rx_byte
// m_        out  m_valid / m_ready   m_command, m_payload_length, m_sequence_res,
//                                    m_data_byte, m_byte_index, m_last
// cmd, seq, an in-range len and payload data bytes each wait while the bit-serial
// crc unit runs its 8 steps; all other link bytes are taken without that wait
// a good frame is read back from the payload ram, one result per ST_RD and ST_LOAD pass,
// longer if m_ready holds the output register; no request is taken while a frame is read back
// aresetn is synchronous, active low; the ram needs no clearing
module escaped_frame_receiver_crc16 #(
    parameter int MAX_PAYLOAD = efr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [efr_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [efr_pkg::BYTE_W-1:0] m_command,
    output logic [efr_pkg::LEN_W-1:0]  m_payload_length,
    output logic [efr_pkg::BYTE_W-1:0] m_sequence_res,
    output logic [efr_pkg::BYTE_W-1:0] m_data_byte,
    output logic [efr_pkg::IDX_W-1:0]  m_byte_index,
    output logic                       m_last
);
    import efr_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_CRC, ST_RD, ST_LOAD} state_t;
    typedef enum logic [2:0] {
        PH_WAIT, PH_CMD, PH_LEN, PH_SEQ, PH_PAY, PH_CRCL, PH_CRCH, PH_END
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] seq_reg, seq_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              esc_reg, esc_next;
    logic [CRC_W-1:0]  rxcrc_reg, rxcrc_next;
    logic [AW-1:0]     k_reg, k_next;

    logic              mv_reg, mv_next;
    logic [BYTE_W-1:0] mcmd_reg, mcmd_next;
    logic [LEN_W-1:0]  mlen_reg, mlen_next;
    logic [BYTE_W-1:0] mseq_reg, mseq_next;
    logic [BYTE_W-1:0] mdata_reg, mdata_next;
    logic [IDX_W-1:0]  midx_reg, midx_next;
    logic              mlast_reg, mlast_next;

    crc_ctrl_t         crc_ctrl;
    crc_stat_t         crc_stat;
    logic [BYTE_W-1:0] crc_data;
    logic [CRC_W-1:0]  crc_val;

    logic              ram_we;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    logic              accept;
    logic [BYTE_W-1:0] ch;
    logic              ch_ok;
    logic              k_last;
    logic              out_free;

    efr_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .data    (crc_data),
        .stat    (crc_stat),
        .crc     (crc_val)
    );

    efr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    assign accept   = s_valid && s_ready;
    assign k_last   = (len_reg == '0) || (LEN_W'(k_reg) + LEN_W'(1) == len_reg);
    assign out_free = !mv_reg || m_ready;

    // payload unescape
    always_comb begin
        ch    = s_rx_byte;
        ch_ok = 1'b1;
        unique case (s_rx_byte)
            ESC_SOF: ch = SOF_BYTE;
            ESC_EOF: ch = EOF_BYTE;
            ESC_ESC: ch = ESC_BYTE;
            default: ch_ok = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        seq_next   = seq_reg;
        count_next = count_reg;
        esc_next   = esc_reg;
        rxcrc_next = rxcrc_reg;
        k_next     = k_reg;
        mv_next    = mv_reg;
        mcmd_next  = mcmd_reg;
        mlen_next  = mlen_reg;
        mseq_next  = mseq_reg;
        mdata_next = mdata_reg;
        midx_next  = midx_reg;
        mlast_next = mlast_reg;
        crc_ctrl   = '0;
        crc_data   = s_rx_byte;
        ram_we     = 1'b0;
        ram_wdata  = ch;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (phase_reg)
                        PH_WAIT: begin
                            if (s_rx_byte == SOF_BYTE) begin
                                phase_next    = PH_CMD;
                                count_next    = '0;
                                esc_next      = 1'b0;
                                crc_ctrl.init = 1'b1;
                            end
                        end
                        PH_CMD: begin
                            cmd_next       = s_rx_byte;
                            crc_ctrl.start = 1'b1;
                            state_next     = ST_CRC;
                            phase_next     = PH_LEN;
                        end
                        PH_LEN: begin
                            if (s_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
                                phase_next = PH_WAIT;
                                count_next = '0;
                                esc_next   = 1'b0;
                            end else begin
                                len_next       = s_rx_byte[LEN_W-1:0];
                                crc_ctrl.start = 1'b1;
                                state_next     = ST_CRC;
                                phase_next     = PH_SEQ;
                            end
                        end
                        PH_SEQ: begin
                            seq_next       = s_rx_byte;
                            crc_ctrl.start = 1'b1;
                            state_next     = ST_CRC;
                            phase_next     = (len_reg != '0) ? PH_PAY : PH_CRCL;
                        end
                        PH_PAY: begin
                            if (esc_reg) begin
                                esc_next = 1'b0;
                            end
                            if (esc_reg && !ch_ok) begin
                                phase_next = PH_WAIT;
                                count_next = '0;
                            end else if (!esc_reg && s_rx_byte == ESC_BYTE) begin
                                esc_next = 1'b1;
                            end else if (!esc_reg && s_rx_byte == SOF_BYTE) begin
                                phase_next    = PH_CMD;
                                count_next    = '0;
                                crc_ctrl.init = 1'b1;
                            end else if (!esc_reg && s_rx_byte == EOF_BYTE) begin
                                phase_next = PH_WAIT;
                                count_next = '0;
                            end else begin
                                crc_data       = esc_reg ? ch : s_rx_byte;
                                ram_wdata      = crc_data;
                                ram_we         = (count_reg < LEN_W'(MAX_PAYLOAD));
                                count_next     = count_reg + LEN_W'(1);
                                crc_ctrl.start = 1'b1;
                                state_next     = ST_CRC;
                                if (count_next >= len_reg) begin
                                    phase_next = PH_CRCL;
                                end
                            end
                        end
                        PH_CRCL: begin
                            rxcrc_next = {{(CRC_W-BYTE_W){1'b0}}, s_rx_byte};
                            phase_next = PH_CRCH;
                        end
                        PH_CRCH: begin
                            rxcrc_next = {s_rx_byte, rxcrc_reg[BYTE_W-1:0]};
                            phase_next = PH_END;
                        end
                        PH_END: begin
                            if (s_rx_byte == EOF_BYTE && crc_val == rxcrc_reg) begin
                                k_next     = '0;
                                state_next = ST_RD;
                            end
                            phase_next = PH_WAIT;
                            count_next = '0;
                            esc_next   = 1'b0;
                        end
                        default: begin
                            phase_next = PH_WAIT;
                        end
                    endcase
                end
            end
            ST_CRC: begin
                if (!crc_stat.busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mcmd_next  = cmd_reg;
                    mlen_next  = len_reg;
                    mseq_next  = seq_reg;
                    mdata_next = (len_reg == '0) ? '0 : ram_rdata;
                    midx_next  = IDX_W'(k_reg);
                    mlast_next = k_last;
                    if (k_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_WAIT;
            cmd_reg   <= '0;
            len_reg   <= '0;
            seq_reg   <= '0;
            count_reg <= '0;
            esc_reg   <= 1'b0;
            rxcrc_reg <= '0;
            k_reg     <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            seq_reg   <= seq_next;
            count_reg <= count_next;
            esc_reg   <= esc_next;
            rxcrc_reg <= rxcrc_next;
            k_reg     <= k_next;
            mv_reg    <= mv_next;
        end
        mcmd_reg  <= mcmd_next;
        mlen_reg  <= mlen_next;
        mseq_reg  <= mseq_next;
        mdata_reg <= mdata_next;
        midx_reg  <= midx_next;
        mlast_reg <= mlast_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = mv_reg;
    assign m_command        = mcmd_reg;
    assign m_payload_length = mlen_reg;
    assign m_sequence_res   = mseq_reg;
    assign m_data_byte      = mdata_reg;
    assign m_byte_index     = midx_reg;
    assign m_last           = mlast_reg;

endmodule

FILE: src/efr_checker.sv
`include "assert_macros.svh"

module efr_assertions (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [efr_pkg::BYTE_W-1:0] s_rx_byte,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [efr_pkg::BYTE_W-1:0] m_command,
    input logic [efr_pkg::LEN_W-1:0]  m_payload_length,
    input logic [efr_pkg::BYTE_W-1:0] m_sequence_res,
    input logic [efr_pkg::BYTE_W-1:0] m_data_byte,
    input logic [efr_pkg::IDX_W-1:0]  m_byte_index,
    input logic                       m_last
);
    import efr_pkg::*;

    logic idx_in_range;
    logic empty_ok;

    assign idx_in_range = (LEN_W'(m_byte_index) < m_payload_length);
    assign empty_ok     = (m_payload_length == '0) && (m_data_byte == '0)
                          && (m_byte_index == '0) && m_last;

    // waiting request holds
    `EFR_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_rx_byte))
    // stalled result holds
    `EFR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_command) && $stable(m_payload_length)
        && $stable(m_sequence_res) && $stable(m_data_byte)
        && $stable(m_byte_index) && $stable(m_last))
    // index inside the payload, or the empty-frame result
    `EFR_ASSERT_NOW(a_idx_range, aclk, aresetn, m_valid, idx_in_range || empty_ok)
    // last result of a nonempty run sits at the final index
    `EFR_ASSERT_NOW(a_last_idx, aclk, aresetn, m_valid && m_last && m_payload_length != '0,
        LEN_W'(m_byte_index) + LEN_W'(1) == m_payload_length)
    // a run is not interrupted by new link bytes
    `EFR_ASSERT_NEXT(a_run_busy, aclk, aresetn, m_valid && m_ready && !m_last,
        m_valid || !s_ready)

endmodule

bind escaped_frame_receiver_crc16 efr_assertions u_efr_assertions (.*);
